### rtl/ahp_pkg.sv
// Shared types, constants and helpers for the archive header parser.
`default_nettype none

package ahp_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 7;
    localparam int FMT_W     = 2;
    localparam int SHORT_W   = 18;
    localparam int LONG_W    = 33;
    localparam int FIELD_CNT = 10;

    // Header format codes held in the configuration register.
    localparam logic [FMT_W-1:0] FMT_BE     = 2'd0;
    localparam logic [FMT_W-1:0] FMT_LE     = 2'd1;
    localparam logic [FMT_W-1:0] FMT_OCT    = 2'd2;
    localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

    localparam logic [BYTE_W-1:0] BIN_MAGIC_HI = 8'h71;
    localparam logic [BYTE_W-1:0] BIN_MAGIC_LO = 8'hC7;
    localparam logic [BYTE_W-1:0] OCT_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] OCT_SEVEN    = 8'h37;

    // Binary layout positions.
    localparam logic [POS_W-1:0] BIN_MTIME_POS   = 7'd16;
    localparam logic [POS_W-1:0] BIN_NAMELEN_POS = 7'd20;
    localparam logic [POS_W-1:0] BIN_FILELEN_POS = 7'd22;
    localparam logic [POS_W-1:0] BIN_LAST        = 7'd25;

    // Octal layout positions.
    localparam logic [POS_W-1:0] OCT_MAGIC_LEN = 7'd6;
    localparam logic [POS_W-1:0] OCT_LAST      = 7'd75;

    typedef enum logic [3:0] {
        FLD_DEV     = 4'd0,
        FLD_INO     = 4'd1,
        FLD_MODE    = 4'd2,
        FLD_UID     = 4'd3,
        FLD_GID     = 4'd4,
        FLD_NLINK   = 4'd5,
        FLD_RDEV    = 4'd6,
        FLD_MTIME   = 4'd7,
        FLD_NAMELEN = 4'd8,
        FLD_FILELEN = 4'd9
    } t_field;

    localparam logic [POS_W-1:0] OCT_START [FIELD_CNT] = '{
        7'd6, 7'd12, 7'd18, 7'd24, 7'd30, 7'd36, 7'd42, 7'd48, 7'd59, 7'd65
    };

    typedef logic [FIELD_CNT-1:0][LONG_W-1:0] t_field_vals;

    // Outcome of decoding one word: pass/fail and an optional field write.
    typedef struct packed {
        logic              ok;
        logic              wr;
        t_field            fld;
        logic [LONG_W-1:0] val;
    } t_upd;

    function automatic logic [LONG_W-1:0] fld_mask(input t_field f,
                                                   input logic [LONG_W-1:0] v);
        logic [LONG_W-1:0] res;
        if (f == FLD_MTIME || f == FLD_FILELEN) begin
            res = v;
        end else begin
            res = {{(LONG_W-SHORT_W){1'b0}}, v[SHORT_W-1:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/ahp_bin_decode.sv
// Binary header decoder: magic check and byte placement into 16/32-bit fields.
`default_nettype none

module ahp_bin_decode (
    input  wire logic                         i_little,
    input  wire logic [ahp_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [ahp_pkg::POS_W-1:0]    i_pos,
    input  wire ahp_pkg::t_field_vals         i_cur,
    output ahp_pkg::t_upd                     o_upd
);
    import ahp_pkg::*;

    logic [1:0]        sh_be;
    logic [1:0]        sh_le;
    logic [1:0]        sh;
    logic [1:0]        q;
    logic              first;
    t_field            fld;
    logic [LONG_W-1:0] v;
    logic [LONG_W-1:0] base;

    always_comb begin
        sh_be = 2'd0;
        sh_le = 2'd0;
        first = 1'b0;
        fld   = FLD_DEV;
        q     = 2'd0;
        // Short fields start on an even position; long fields span four bytes.
        priority if (i_pos < BIN_MTIME_POS) begin
            fld   = t_field'(i_pos[4:1] - 4'd1);
            first = ~i_pos[0];
            sh_be = {1'b0, ~i_pos[0]};
            sh_le = {1'b0, i_pos[0]};
        end else if (i_pos < BIN_NAMELEN_POS) begin
            q     = i_pos[1:0];
            fld   = FLD_MTIME;
            first = (q == 2'd0);
            sh_be = ~q;
            sh_le = {~q[1], q[0]};
        end else if (i_pos < BIN_FILELEN_POS) begin
            fld   = FLD_NAMELEN;
            first = ~i_pos[0];
            sh_be = {1'b0, ~i_pos[0]};
            sh_le = {1'b0, i_pos[0]};
        end else begin
            q     = i_pos[1:0] - 2'd2;
            fld   = FLD_FILELEN;
            first = (q == 2'd0);
            sh_be = ~q;
            sh_le = {~q[1], q[0]};
        end

        sh   = i_little ? sh_le : sh_be;
        v    = {{(LONG_W-BYTE_W){1'b0}}, i_byte} << {sh, 3'b000};
        base = first ? '0 : i_cur[fld];

        o_upd     = '0;
        o_upd.fld = fld;
        o_upd.val = fld_mask(fld, base | v);
        priority if (i_pos > BIN_LAST) begin
            o_upd.ok = 1'b0;
        end else if (i_pos == 7'd0) begin
            o_upd.ok = (i_byte == (i_little ? BIN_MAGIC_LO : BIN_MAGIC_HI));
        end else if (i_pos == 7'd1) begin
            o_upd.ok = (i_byte == (i_little ? BIN_MAGIC_HI : BIN_MAGIC_LO));
        end else begin
            o_upd.ok = 1'b1;
            o_upd.wr = 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/ahp_oct_decode.sv
// Octal ASCII header decoder: digit check, magic check and digit accumulation.
`default_nettype none

module ahp_oct_decode (
    input  wire logic [ahp_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [ahp_pkg::POS_W-1:0]    i_pos,
    input  wire ahp_pkg::t_field_vals         i_cur,
    output ahp_pkg::t_upd                     o_upd
);
    import ahp_pkg::*;

    logic              is_digit;
    logic [2:0]        d;
    logic              first;
    t_field            fld;
    logic [LONG_W-1:0] base;

    always_comb begin
        is_digit = (i_byte >= OCT_ZERO) && (i_byte <= OCT_SEVEN);
        d        = i_byte[2:0];

        fld = FLD_DEV;
        for (int f = 1; f < FIELD_CNT; f++) begin
            if (i_pos >= OCT_START[f]) begin
                fld = t_field'(4'(f));
            end
        end
        // The first digit of a field starts a fresh value.
        first = (i_pos == OCT_START[fld]);
        base  = first ? '0 : i_cur[fld];

        o_upd     = '0;
        o_upd.fld = fld;
        o_upd.val = fld_mask(fld, {base[LONG_W-4:0], 3'b000}
                                  + {{(LONG_W-3){1'b0}}, d});
        priority if (!is_digit) begin
            o_upd.ok = 1'b0;
        end else if (i_pos > OCT_LAST) begin
            o_upd.ok = 1'b0;
        end else if (i_pos < OCT_MAGIC_LEN) begin
            // Magic is 070707: even positions hold 0, odd positions hold 7.
            o_upd.ok = (d == (i_pos[0] ? 3'd7 : 3'd0));
        end else begin
            o_upd.ok = 1'b1;
            o_upd.wr = 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/archive_header_parser.sv
// Top level of the archive header parser: input register, decode, field state, result.
`default_nettype none

// Parses cpio-style archive headers one byte per word. Each input word carries a header
// byte and its offset in the header; each produces one result word with an error flag,
// a last-byte flag and all ten decoded fields as they stand after that byte. The format
// register selects big-endian binary, little-endian binary or octal ASCII; the user must
// write it only while the block is idle, as the block itself does not enforce this. A word
// is registered on acceptance and decoded in the next cycle; the result is registered in
// the output stage once that is free. The block takes one word every cycle while the
// output is not stalled. Bytes that fail a check leave every field unchanged.
module archive_header_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [ahp_pkg::FMT_W-1:0]   i_cfg_wr_data,
    input  wire logic                        i_valid,
    output      logic                        o_stall,
    input  wire logic [ahp_pkg::BYTE_W-1:0]  i_header_byte,
    input  wire logic [ahp_pkg::POS_W-1:0]   i_byte_position,
    output      logic                        o_valid,
    input  wire logic                        i_stall,
    output      logic                        o_error_flag,
    output      logic                        o_header_done,
    output      logic [ahp_pkg::SHORT_W-1:0] o_device_number,
    output      logic [ahp_pkg::SHORT_W-1:0] o_inode_number,
    output      logic [ahp_pkg::SHORT_W-1:0] o_file_mode,
    output      logic [ahp_pkg::SHORT_W-1:0] o_user_id,
    output      logic [ahp_pkg::SHORT_W-1:0] o_group_id,
    output      logic [ahp_pkg::SHORT_W-1:0] o_link_count,
    output      logic [ahp_pkg::SHORT_W-1:0] o_special_device,
    output      logic [ahp_pkg::LONG_W-1:0]  o_modify_time,
    output      logic [ahp_pkg::SHORT_W-1:0] o_name_length,
    output      logic [ahp_pkg::LONG_W-1:0]  o_file_length
);
    import ahp_pkg::*;

    logic [FMT_W-1:0]   r_format;
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic [POS_W-1:0]   r_in_pos;
    logic               r_out_valid;
    logic               r_out_err;
    logic               r_out_done;
    logic [SHORT_W-1:0] r_dev, r_ino, r_mode, r_uid, r_gid, r_nlink, r_rdev, r_namelen;
    logic [LONG_W-1:0]  r_mtime, r_filelen;

    logic               n_out_err;
    logic               n_out_done;
    t_field_vals        cur;
    t_upd               bin_upd;
    t_upd               oct_upd;
    t_upd               upd;
    logic               out_free;
    logic               advance;
    logic               in_accept;

    assign cur[FLD_DEV]     = {{(LONG_W-SHORT_W){1'b0}}, r_dev};
    assign cur[FLD_INO]     = {{(LONG_W-SHORT_W){1'b0}}, r_ino};
    assign cur[FLD_MODE]    = {{(LONG_W-SHORT_W){1'b0}}, r_mode};
    assign cur[FLD_UID]     = {{(LONG_W-SHORT_W){1'b0}}, r_uid};
    assign cur[FLD_GID]     = {{(LONG_W-SHORT_W){1'b0}}, r_gid};
    assign cur[FLD_NLINK]   = {{(LONG_W-SHORT_W){1'b0}}, r_nlink};
    assign cur[FLD_RDEV]    = {{(LONG_W-SHORT_W){1'b0}}, r_rdev};
    assign cur[FLD_MTIME]   = r_mtime;
    assign cur[FLD_NAMELEN] = {{(LONG_W-SHORT_W){1'b0}}, r_namelen};
    assign cur[FLD_FILELEN] = r_filelen;

    ahp_bin_decode u_bin (
        .i_little (r_format == FMT_LE),
        .i_byte   (r_in_byte),
        .i_pos    (r_in_pos),
        .i_cur    (cur),
        .o_upd    (bin_upd)
    );

    ahp_oct_decode u_oct (
        .i_byte   (r_in_byte),
        .i_pos    (r_in_pos),
        .i_cur    (cur),
        .o_upd    (oct_upd)
    );

    always_comb begin
        unique case (r_format)
            FMT_BE, FMT_LE: begin
                upd        = bin_upd;
                n_out_done = (r_in_pos == BIN_LAST);
            end
            FMT_OCT: begin
                upd        = oct_upd;
                n_out_done = (r_in_pos == OCT_LAST);
            end
            default: begin
                upd        = '0;
                n_out_done = 1'b0;
            end
        endcase
        n_out_err = ~upd.ok;
    end

    // The field registers double as the result payload: they only move when a
    // decoded word is loaded into the free output stage.
    assign out_free  = ~r_out_valid | ~i_stall;
    assign advance   = r_in_valid & out_free;
    assign o_stall   = r_in_valid & ~out_free;
    assign in_accept = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= FMT_BE;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_format <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_header_byte;
            r_in_pos  <= i_byte_position;
        end
        if (advance) begin
            r_out_err  <= n_out_err;
            r_out_done <= n_out_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev     <= '0;
            r_ino     <= '0;
            r_mode    <= '0;
            r_uid     <= '0;
            r_gid     <= '0;
            r_nlink   <= '0;
            r_rdev    <= '0;
            r_mtime   <= '0;
            r_namelen <= '0;
            r_filelen <= '0;
        end else if (advance && upd.ok && upd.wr) begin
            unique case (upd.fld)
                FLD_DEV:     r_dev     <= upd.val[SHORT_W-1:0];
                FLD_INO:     r_ino     <= upd.val[SHORT_W-1:0];
                FLD_MODE:    r_mode    <= upd.val[SHORT_W-1:0];
                FLD_UID:     r_uid     <= upd.val[SHORT_W-1:0];
                FLD_GID:     r_gid     <= upd.val[SHORT_W-1:0];
                FLD_NLINK:   r_nlink   <= upd.val[SHORT_W-1:0];
                FLD_RDEV:    r_rdev    <= upd.val[SHORT_W-1:0];
                FLD_MTIME:   r_mtime   <= upd.val;
                FLD_NAMELEN: r_namelen <= upd.val[SHORT_W-1:0];
                FLD_FILELEN: r_filelen <= upd.val;
                default: ;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_error_flag     = r_out_err;
    assign o_header_done    = r_out_done;
    assign o_device_number  = r_dev;
    assign o_inode_number   = r_ino;
    assign o_file_mode      = r_mode;
    assign o_user_id        = r_uid;
    assign o_group_id       = r_gid;
    assign o_link_count     = r_nlink;
    assign o_special_device = r_rdev;
    assign o_modify_time    = r_mtime;
    assign o_name_length    = r_namelen;
    assign o_file_length    = r_filelen;

endmodule

`default_nettype wire

### rtl/ahp_checker.sv
// Port-level assertions for the archive header parser, bound to the top level.
`default_nettype none

module ahp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic                        o_error_flag,
    input wire logic                        o_header_done,
    input wire logic [ahp_pkg::SHORT_W-1:0] o_device_number,
    input wire logic [ahp_pkg::SHORT_W-1:0] o_file_mode,
    input wire logic [ahp_pkg::LONG_W-1:0]  o_modify_time,
    input wire logic [ahp_pkg::LONG_W-1:0]  o_file_length
);
    import ahp_pkg::*;

    // A held result word keeps its flags.
    a_hold_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_error_flag) && $stable(o_header_done))
        else $error("result flags changed while stalled");

    // A held result word keeps its modify-time and file-length fields.
    a_hold_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_modify_time) && $stable(o_file_length))
        else $error("result fields changed while stalled");

    // Input back-pressure only arises from a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with the output free");

    // Device number, file mode, modify time and file length only move together with a new result word.
    a_fields_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && $past(i_rst_n) |-> $stable(o_device_number) && $stable(o_file_mode)
                                       && $stable(o_modify_time) && $stable(o_file_length))
        else $error("fields changed without a result word");

endmodule

bind archive_header_parser ahp_checker u_ahp_checker (.*);

`default_nettype wire
